// ===== sv/prr_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, register indexes and types of the page replacement unit.
package prr_pkg;

    // Table sizes and field widths.
    localparam int NUM_PAGES  = 32;
    localparam int MAX_FRAMES = 32;
    localparam int TIME_BITS  = 16;
    localparam int PAGE_W     = $clog2(NUM_PAGES);
    localparam int FRAME_W    = $clog2(MAX_FRAMES);
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
    localparam int FAULT_W    = 16;

    localparam logic [FAULT_W-1:0] FAULT_MAX = '1;
    localparam logic [CNT_W-1:0]   FRAMES_RST = CNT_W'(4);

    // Configuration register indexes.
    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_FRAMES = 1'b1;

    // Policy codes.
    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    // One entry presented to the victim search unit.
    typedef struct packed {
        logic                 vld;
        logic                 resident;
        logic [PAGE_W-1:0]    idx;
        logic [TIME_BITS-1:0] stamp;
    } t_scan_in;

endpackage

// ===== sv/prr_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
module prr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/prr_scan.sv =====
`timescale 1ns / 1ps
// Age compare unit that tracks the least recently used resident page.
module prr_scan (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  logic [prr_pkg::TIME_BITS-1:0] i_now,
    input  prr_pkg::t_scan_in             i_entry,
    output logic [prr_pkg::PAGE_W-1:0]    o_victim
);

    logic                          r_found;
    logic [prr_pkg::PAGE_W-1:0]    r_best;
    logic [prr_pkg::TIME_BITS-1:0] r_best_age;
    logic                          n_found;
    logic [prr_pkg::PAGE_W-1:0]    n_best;
    logic [prr_pkg::TIME_BITS-1:0] n_best_age;
    logic [prr_pkg::TIME_BITS-1:0] age;

    // Age wraps with the access clock, so the order survives a time wrap.
    assign age = i_now - i_entry.stamp;

    // Strictly greater keeps the lowest page index on a tie.
    always_comb begin
        n_found    = r_found;
        n_best     = r_best;
        n_best_age = r_best_age;
        if (i_clear) begin
            n_found = 1'b0;
            n_best  = '0;
        end else if (i_entry.vld && i_entry.resident && (!r_found || age > r_best_age)) begin
            n_found    = 1'b1;
            n_best     = i_entry.idx;
            n_best_age = age;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_best  <= '0;
        end else begin
            r_found <= n_found;
            r_best  <= n_best;
        end
        r_best_age <= n_best_age;
    end

    assign o_victim = r_best;

endmodule

// ===== sv/page_replacement_fifo_lru.sv =====
`timescale 1ns / 1ps
// Page replacement unit: top level with the sequencer, tables and output register.
//
// Each input word on the s_axis channel is one page reference: tdata carries the
// page number and tuser the restart flag, which clears residency, the load-order
// ring position, the frame fill count, the access clock and the fault count before
// the reference is handled. Each reference yields exactly one output word on the
// m_axis channel with the hit and eviction flags in tuser and the frame, evicted
// page and saturating fault count in tdata.
// The block works on one reference at a time and is not ready meanwhile. On an LRU
// eviction the last-use time memory is read one page per cycle over all 32 pages,
// then the load-order ring is read one slot per cycle to find the victim's slot.
// The next reference can be accepted in the same cycle as the result enters the
// output register.
// The result waits in an output register; while the receiver stalls, a finished
// result is held in the sequencer until the register is free.
// Configuration writes (policy, frame count) are always ready; the user must make
// them while the block is idle, which is not enforced. Reset restores FIFO policy
// and four frames and clears all control state; no memory clearing pass is needed.
module page_replacement_fifo_lru (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [5:0]  i_cfg_data,
    // Reference input.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [4:0] page_number, [7:5] zero
    input  logic        i_s_axis_tuser,   // [0] restart
    // Result output.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [4:0] frame_index, [9:5] evicted_page,
                                          // [25:10] miss_count, [31:26] zero
    output logic [1:0]  o_m_axis_tuser    // [0] hit, [1] evicted_valid
);

    localparam int PW = prr_pkg::PAGE_W;
    localparam int FW = prr_pkg::FRAME_W;
    localparam int CW = prr_pkg::CNT_W;
    localparam int TW = prr_pkg::TIME_BITS;
    localparam int QW = prr_pkg::FAULT_W;

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHK   = 4'd1;
    localparam logic [3:0] S_HITW  = 4'd2;
    localparam logic [3:0] S_FRD   = 4'd3;
    localparam logic [3:0] S_LRU   = 4'd4;
    localparam logic [3:0] S_RSCAN = 4'd5;
    localparam logic [3:0] S_RWR   = 4'd6;
    localparam logic [3:0] S_VWT   = 4'd7;
    localparam logic [3:0] S_UPD   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0]           r_state, n_state;
    logic [PW-1:0]        r_page, n_page;
    logic [prr_pkg::NUM_PAGES-1:0] r_resident, n_resident;
    logic [FW-1:0]        r_head, n_head;
    logic [CW-1:0]        r_fu, n_fu;
    logic [TW-1:0]        r_time, n_time;
    logic [QW-1:0]        r_fault, n_fault;
    logic                 r_policy, n_policy;
    logic [CW-1:0]        r_fcount, n_fcount;
    logic                 r_hit, n_hit;
    logic [FW-1:0]        r_frame, n_frame;
    logic                 r_evv, n_evv;
    logic [PW-1:0]        r_victim, n_victim;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic                 r_lv, n_lv;
    logic [PW-1:0]        r_lidx, n_lidx;
    logic                 r_rv, n_rv;
    logic [FW-1:0]        r_rslot, n_rslot;
    logic [FW-1:0]        r_slot, n_slot;
    logic                 r_sfound, n_sfound;
    logic                 r_ovld, n_ovld;
    logic [31:0]          r_otdata, n_otdata;
    logic [1:0]           r_otuser, n_otuser;

    logic                 in_acc;
    logic                 out_free;
    logic [CW-1:0]        usable;
    logic [FW-1:0]        scan_addr;

    logic                 ring_we;
    logic [FW-1:0]        ring_waddr;
    logic [FW-1:0]        ring_raddr;
    logic [PW-1:0]        ring_rdata;
    logic [PW-1:0]        fop_raddr;
    logic [FW-1:0]        fop_rdata;
    logic [TW-1:0]        lut_rdata;
    logic                 upd_we;

    prr_pkg::t_scan_in    scan_entry;
    logic [PW-1:0]        scan_victim;

    // Handshakes.
    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_ovld || i_m_axis_tready;

    // Frame count clamped to the range 1 to MAX_FRAMES.
    always_comb begin
        if (r_fcount == '0) begin
            usable = CW'(1);
        end else if (r_fcount > CW'(prr_pkg::MAX_FRAMES)) begin
            usable = CW'(prr_pkg::MAX_FRAMES);
        end else begin
            usable = r_fcount;
        end
    end

    assign scan_addr = r_head + r_cnt[FW-1:0];
    assign upd_we    = (r_state == S_UPD);

    // Entry fed to the age compare unit in the cycle after its memory read.
    assign scan_entry.vld      = r_lv;
    assign scan_entry.resident = r_resident[r_lidx];
    assign scan_entry.idx      = r_lidx;
    assign scan_entry.stamp    = lut_rdata;

    // Sequencer and table control.
    always_comb begin
        n_state    = r_state;
        n_page     = r_page;
        n_resident = r_resident;
        n_head     = r_head;
        n_fu       = r_fu;
        n_time     = r_time;
        n_fault    = r_fault;
        n_policy   = r_policy;
        n_fcount   = r_fcount;
        n_hit      = r_hit;
        n_frame    = r_frame;
        n_evv      = r_evv;
        n_victim   = r_victim;
        n_cnt      = r_cnt;
        n_lv       = 1'b0;
        n_lidx     = r_cnt[PW-1:0];
        n_rv       = 1'b0;
        n_rslot    = scan_addr;
        n_slot     = r_slot;
        n_sfound   = r_sfound;
        n_ovld     = r_ovld && !i_m_axis_tready;
        n_otdata   = r_otdata;
        n_otuser   = r_otuser;
        ring_we    = 1'b0;
        ring_waddr = r_head;
        ring_raddr = r_head;
        fop_raddr  = r_page;

        // Configuration writes.
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                prr_pkg::REG_POLICY: n_policy = i_cfg_data[0];
                prr_pkg::REG_FRAMES: n_fcount = i_cfg_data;
                default:             n_policy = r_policy;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_page  = i_s_axis_tdata[PW-1:0];
                    n_state = S_CHK;
                    if (i_s_axis_tuser) begin
                        n_resident = '0;
                        n_head     = '0;
                        n_fu       = '0;
                        n_time     = '0;
                        n_fault    = '0;
                    end
                end
            end
            S_CHK: begin
                n_evv = 1'b0;
                if (r_resident[r_page]) begin
                    n_hit   = 1'b1;
                    n_state = S_HITW;
                end else begin
                    n_hit = 1'b0;
                    if (r_fault != prr_pkg::FAULT_MAX) begin
                        n_fault = r_fault + QW'(1);
                    end
                    if (r_fu < usable) begin
                        // Free frame: handed out in fill order.
                        n_frame    = r_fu[FW-1:0];
                        ring_we    = 1'b1;
                        ring_waddr = r_head + r_fu[FW-1:0];
                        n_fu       = r_fu + CW'(1);
                        n_state    = S_UPD;
                    end else if (r_policy == prr_pkg::POLICY_FIFO) begin
                        n_state = S_FRD;
                    end else begin
                        n_cnt   = '0;
                        n_state = S_LRU;
                    end
                end
            end
            S_HITW: begin
                n_frame = fop_rdata;
                n_state = S_UPD;
            end
            S_FRD: begin
                // Oldest loaded page leaves; the new page takes its ring slot.
                n_victim   = ring_rdata;
                fop_raddr  = ring_rdata;
                ring_we    = 1'b1;
                ring_waddr = r_head;
                n_head     = r_head + FW'(1);
                n_state    = S_VWT;
            end
            S_LRU: begin
                if (r_cnt == CW'(prr_pkg::NUM_PAGES)) begin
                    n_cnt    = '0;
                    n_sfound = 1'b0;
                    n_state  = S_RSCAN;
                end else begin
                    n_lv  = 1'b1;
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_RSCAN: begin
                ring_raddr = scan_addr;
                if (r_rv && !r_sfound && ring_rdata == scan_victim) begin
                    n_sfound = 1'b1;
                    n_slot   = r_rslot;
                end
                if (r_cnt == r_fu) begin
                    n_state = S_RWR;
                end else begin
                    n_rv  = 1'b1;
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_RWR: begin
                ring_we    = 1'b1;
                ring_waddr = r_sfound ? r_slot : r_head;
                n_victim   = scan_victim;
                fop_raddr  = scan_victim;
                n_state    = S_VWT;
            end
            S_VWT: begin
                n_frame              = fop_rdata;
                n_evv                = 1'b1;
                n_resident[r_victim] = 1'b0;
                n_state              = S_UPD;
            end
            S_UPD: begin
                n_resident[r_page] = 1'b1;
                n_time             = r_time + TW'(1);
                n_state            = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_ovld   = 1'b1;
                    n_otdata = {6'b0, r_fault, (r_evv ? r_victim : PW'(0)), r_frame};
                    n_otuser = {r_evv, r_hit};
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers are reset; payload registers are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_resident <= '0;
            r_head     <= '0;
            r_fu       <= '0;
            r_time     <= '0;
            r_fault    <= '0;
            r_policy   <= prr_pkg::POLICY_FIFO;
            r_fcount   <= prr_pkg::FRAMES_RST;
            r_lv       <= 1'b0;
            r_rv       <= 1'b0;
            r_sfound   <= 1'b0;
            r_ovld     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_resident <= n_resident;
            r_head     <= n_head;
            r_fu       <= n_fu;
            r_time     <= n_time;
            r_fault    <= n_fault;
            r_policy   <= n_policy;
            r_fcount   <= n_fcount;
            r_lv       <= n_lv;
            r_rv       <= n_rv;
            r_sfound   <= n_sfound;
            r_ovld     <= n_ovld;
        end
        r_page   <= n_page;
        r_hit    <= n_hit;
        r_frame  <= n_frame;
        r_evv    <= n_evv;
        r_victim <= n_victim;
        r_cnt    <= n_cnt;
        r_lidx   <= n_lidx;
        r_rslot  <= n_rslot;
        r_slot   <= n_slot;
        r_otdata <= n_otdata;
        r_otuser <= n_otuser;
    end

    // Load-order ring.
    prr_ram #(.WIDTH(PW), .DEPTH(prr_pkg::MAX_FRAMES)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (r_page),
        .i_raddr (ring_raddr),
        .o_rdata (ring_rdata)
    );

    // Frame held by each page.
    prr_ram #(.WIDTH(FW), .DEPTH(prr_pkg::NUM_PAGES)) u_frame_tbl (
        .i_clk   (i_clk),
        .i_we    (upd_we),
        .i_waddr (r_page),
        .i_wdata (r_frame),
        .i_raddr (fop_raddr),
        .o_rdata (fop_rdata)
    );

    // Last-use time of each page.
    prr_ram #(.WIDTH(TW), .DEPTH(prr_pkg::NUM_PAGES)) u_time_tbl (
        .i_clk   (i_clk),
        .i_we    (upd_we),
        .i_waddr (r_page),
        .i_wdata (r_time),
        .i_raddr (r_cnt[PW-1:0]),
        .o_rdata (lut_rdata)
    );

    // Least recently used search.
    prr_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (r_state == S_CHK),
        .i_now    (r_time),
        .i_entry  (scan_entry),
        .o_victim (scan_victim)
    );

    assign o_m_axis_tvalid = r_ovld;
    assign o_m_axis_tdata  = r_otdata;
    assign o_m_axis_tuser  = r_otuser;

endmodule
